// ----- rtl/qvr_pkg.sv -----
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int VEC_WIDTH_DEF = 24;

    // quaternion word: signed Q2.14
    localparam int QW     = 16;
    localparam int Q_FRAC = 14;

    // products of two quaternion words, and coefficients (Q.28, two guard bits)
    localparam int PROD_W = 2 * QW;
    localparam int COEF_W = PROD_W + 2;

    // coefficient * vector has 2*Q_FRAC extra fraction bits
    localparam int ROUND_SHIFT = 2 * Q_FRAC;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = QW;

    localparam logic signed [QW-1:0] ROT_W_RST = 16'sd16384;   // 1.0
    localparam logic signed [QW-1:0] ROT_V_RST = 16'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_W,
        CFG_ROT_X,
        CFG_ROT_Y,
        CFG_ROT_Z
    } cfg_idx_t;

    typedef logic signed [QW-1:0]     quat_word_t;
    typedef logic signed [PROD_W-1:0] prod_word_t;
    typedef logic signed [COEF_W-1:0] coef_word_t;

    typedef struct packed {
        quat_word_t w;
        quat_word_t x;
        quat_word_t y;
        quat_word_t z;
    } quat_t;

    typedef struct packed {
        prod_word_t ww;
        prod_word_t xx;
        prod_word_t yy;
        prod_word_t zz;
        prod_word_t xy;
        prod_word_t xz;
        prod_word_t yz;
        prod_word_t wx;
        prod_word_t wy;
        prod_word_t wz;
    } quat_prod_t;

    typedef struct packed {
        coef_word_t m00;
        coef_word_t m01;
        coef_word_t m02;
        coef_word_t m10;
        coef_word_t m11;
        coef_word_t m12;
        coef_word_t m20;
        coef_word_t m21;
        coef_word_t m22;
    } coef_mat_t;

    function automatic coef_word_t ext_prod(prod_word_t p);
        return COEF_W'(p);
    endfunction

endpackage

// ----- rtl/qvr_if.sv -----
`timescale 1ns / 1ps

interface qvr_in_if
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic signed [VEC_WIDTH-1:0] in_x;
    logic signed [VEC_WIDTH-1:0] in_y;
    logic signed [VEC_WIDTH-1:0] in_z;

    modport source (output valid, mode, in_x, in_y, in_z, input ready);
    modport sink   (input valid, mode, in_x, in_y, in_z, output ready);
endinterface

interface qvr_out_if
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ----- rtl/quaternion_vector_rotate.sv -----
`timescale 1ns / 1ps

// Channel    Kind          Payload
// ---------  ------------  ------------------------------------------------
// sample     valid/ready   mode, in_x, in_y, in_z (signed, 16 frac bits)
// result     valid/ready   out_x, out_y, out_z, saturated
// cfg        write only    cfg_we, cfg_index (0 w, 1 x, 2 y, 3 z), cfg_data
//
// One item per cycle sustained while result does not stall.
// The five stage registers: quaternion products, rotation matrix, nine
// coefficient*component products, row sums, rounded/clipped output.
// Reset clears all stage valids and loads q = 1.0 (identity rotation).
// Each stage advances when its successor is empty or advancing, so a stall
// on result backs up stage by stage and bubbles are squeezed out.
module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    qvr_in_if.sink                sample,
    qvr_out_if.source             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W = COEF_W + VEC_WIDTH + 2;
    localparam logic [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    quat_t rot_reg;
    quat_t rot_next;

    // rotation quaternion registers
    always_comb
    begin
        rot_next = rot_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROT_W: rot_next.w = cfg_data;
                CFG_ROT_X: rot_next.x = cfg_data;
                CFG_ROT_Y: rot_next.y = cfg_data;
                CFG_ROT_Z: rot_next.z = cfg_data;
                default:   rot_next = rot_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg.w <= ROT_W_RST;
            rot_reg.x <= ROT_V_RST;
            rot_reg.y <= ROT_V_RST;
            rot_reg.z <= ROT_V_RST;
        end
        else
            rot_reg <= rot_next;
    end

    // pipeline plumbing
    logic signed [VEC_WIDTH-1:0] in_vec   [3];
    logic signed [VEC_WIDTH-1:0] coef_vec [3];
    logic signed [SUM_W-1:0]     row_sum  [3];
    logic signed [VEC_WIDTH-1:0] res_vec  [3];
    coef_mat_t                   coef;
    logic                        coef_valid;
    logic                        coef_ready;
    logic                        sum_valid;
    logic                        sum_ready;

    assign in_vec[0] = sample.in_x;
    assign in_vec[1] = sample.in_y;
    assign in_vec[2] = sample.in_z;

    qvr_coef #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .rot        (rot_reg),
        .item_valid (sample.valid),
        .item_ready (sample.ready),
        .mode       (sample.mode),
        .vec        (in_vec),
        .fwd_valid  (coef_valid),
        .fwd_ready  (coef_ready),
        .coef       (coef),
        .fwd_vec    (coef_vec)
    );

    qvr_mac #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (coef_valid),
        .item_ready (coef_ready),
        .coef       (coef),
        .vec        (coef_vec),
        .fwd_valid  (sum_valid),
        .fwd_ready  (sum_ready),
        .sum        (row_sum)
    );

    qvr_sat #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (sum_valid),
        .item_ready (sum_ready),
        .sum        (row_sum),
        .fwd_valid  (result.valid),
        .fwd_ready  (result.ready),
        .res        (res_vec),
        .saturated  (result.saturated)
    );

    assign result.out_x = res_vec[0];
    assign result.out_y = res_vec[1];
    assign result.out_z = res_vec[2];

`ifndef ASSERT_OFF
    // a taken result frees the whole chain, so the input side must be open
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> sample.ready)
        else $error("sample not ready while result side is ready");

    // with the sink open, an accepted item shows up after five stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready && result.ready ##1 result.ready
        ##1 result.ready ##1 result.ready ##1 result.ready |=> result.valid)
        else $error("item lost in pipeline");

    // a clipped result has at least one component at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.out_x == VEC_MAX || result.out_x == VEC_MIN ||
            result.out_y == VEC_MAX || result.out_y == VEC_MIN ||
            result.out_z == VEC_MAX || result.out_z == VEC_MIN)
        else $error("saturated flag without clipped component");
`endif

endmodule

// ----- rtl/qvr_coef.sv -----
`timescale 1ns / 1ps

// Two stages: quaternion products, then the 3x3 rotation matrix.
module qvr_coef
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  quat_t                       rot,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        mode,
    input  logic signed [VEC_WIDTH-1:0] vec [3],
    output logic                        fwd_valid,
    input  logic                        fwd_ready,
    output coef_mat_t                   coef,
    output logic signed [VEC_WIDTH-1:0] fwd_vec [3]
);

    logic                        s1_valid_reg;
    logic                        s1_mode_reg;
    quat_prod_t                  s1_prod_reg;
    quat_prod_t                  s1_prod_next;
    logic signed [VEC_WIDTH-1:0] s1_vec_reg [3];

    logic                        s2_valid_reg;
    coef_mat_t                   s2_coef_reg;
    coef_mat_t                   s2_coef_next;
    logic signed [VEC_WIDTH-1:0] s2_vec_reg [3];

    logic adv1;
    logic adv2;

    assign adv2       = !s2_valid_reg || fwd_ready;
    assign adv1       = !s1_valid_reg || adv2;
    assign item_ready = adv1;

    always_comb
    begin
        s1_prod_next.ww = $signed(rot.w) * $signed(rot.w);
        s1_prod_next.xx = $signed(rot.x) * $signed(rot.x);
        s1_prod_next.yy = $signed(rot.y) * $signed(rot.y);
        s1_prod_next.zz = $signed(rot.z) * $signed(rot.z);
        s1_prod_next.xy = $signed(rot.x) * $signed(rot.y);
        s1_prod_next.xz = $signed(rot.x) * $signed(rot.z);
        s1_prod_next.yz = $signed(rot.y) * $signed(rot.z);
        s1_prod_next.wx = $signed(rot.w) * $signed(rot.x);
        s1_prod_next.wy = $signed(rot.w) * $signed(rot.y);
        s1_prod_next.wz = $signed(rot.w) * $signed(rot.z);
    end

    // inverse rotation flips the sign of the real part in the cross terms
    always_comb
    begin
        coef_word_t ww, xx, yy, zz, xy, xz, yz, sx, sy, sz;
        ww = ext_prod(s1_prod_reg.ww);
        xx = ext_prod(s1_prod_reg.xx);
        yy = ext_prod(s1_prod_reg.yy);
        zz = ext_prod(s1_prod_reg.zz);
        xy = ext_prod(s1_prod_reg.xy);
        xz = ext_prod(s1_prod_reg.xz);
        yz = ext_prod(s1_prod_reg.yz);
        sx = s1_mode_reg ? -ext_prod(s1_prod_reg.wx) : ext_prod(s1_prod_reg.wx);
        sy = s1_mode_reg ? -ext_prod(s1_prod_reg.wy) : ext_prod(s1_prod_reg.wy);
        sz = s1_mode_reg ? -ext_prod(s1_prod_reg.wz) : ext_prod(s1_prod_reg.wz);

        s2_coef_next.m00 = ww + xx - yy - zz;
        s2_coef_next.m11 = ww - xx + yy - zz;
        s2_coef_next.m22 = ww - xx - yy + zz;
        s2_coef_next.m01 = (xy - sz) <<< 1;
        s2_coef_next.m02 = (xz + sy) <<< 1;
        s2_coef_next.m10 = (xy + sz) <<< 1;
        s2_coef_next.m12 = (yz - sx) <<< 1;
        s2_coef_next.m20 = (xz - sy) <<< 1;
        s2_coef_next.m21 = (yz + sx) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= item_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_mode_reg <= mode;
            s1_prod_reg <= s1_prod_next;
            s1_vec_reg  <= vec;
        end
        if (adv2)
        begin
            s2_coef_reg <= s2_coef_next;
            s2_vec_reg  <= s1_vec_reg;
        end
    end

    assign fwd_valid = s2_valid_reg;
    assign coef      = s2_coef_reg;
    assign fwd_vec   = s2_vec_reg;

endmodule

// ----- rtl/qvr_mac.sv -----
`timescale 1ns / 1ps

// Two stages: nine coefficient*component products, then row sums with
// the half-LSB rounding constant folded in.
module qvr_mac
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      item_valid,
    output logic                                      item_ready,
    input  coef_mat_t                                 coef,
    input  logic signed [VEC_WIDTH-1:0]               vec [3],
    output logic                                      fwd_valid,
    input  logic                                      fwd_ready,
    output logic signed [COEF_W+VEC_WIDTH+1:0]        sum [3]
);

    localparam int PW    = COEF_W + VEC_WIDTH;
    localparam int SUM_W = PW + 2;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (ROUND_SHIFT - 1);

    coef_word_t              cm [3][3];
    logic                    s3_valid_reg;
    logic signed [PW-1:0]    s3_prod_reg  [3][3];
    logic signed [PW-1:0]    s3_prod_next [3][3];
    logic                    s4_valid_reg;
    logic signed [SUM_W-1:0] s4_sum_reg   [3];
    logic signed [SUM_W-1:0] s4_sum_next  [3];
    logic                    adv3;
    logic                    adv4;

    assign cm[0][0] = coef.m00;
    assign cm[0][1] = coef.m01;
    assign cm[0][2] = coef.m02;
    assign cm[1][0] = coef.m10;
    assign cm[1][1] = coef.m11;
    assign cm[1][2] = coef.m12;
    assign cm[2][0] = coef.m20;
    assign cm[2][1] = coef.m21;
    assign cm[2][2] = coef.m22;

    assign adv4       = !s4_valid_reg || fwd_ready;
    assign adv3       = !s3_valid_reg || adv4;
    assign item_ready = adv3;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                s3_prod_next[i][j] = PW'($signed(cm[i][j])) * PW'(vec[j]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s4_sum_next[i] = SUM_W'(s3_prod_reg[i][0]) + SUM_W'(s3_prod_reg[i][1])
                           + SUM_W'(s3_prod_reg[i][2]) + RND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
                s3_valid_reg <= item_valid;
            if (adv4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
            s3_prod_reg <= s3_prod_next;
        if (adv4)
            s4_sum_reg <= s4_sum_next;
    end

    assign fwd_valid = s4_valid_reg;
    assign sum       = s4_sum_reg;

endmodule

// ----- rtl/qvr_sat.sv -----
`timescale 1ns / 1ps

// Output register: drop the 28 fraction bits, clip to the vector range.
module qvr_sat
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = VEC_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [COEF_W+VEC_WIDTH+1:0] sum [3],
    output logic                               fwd_valid,
    input  logic                               fwd_ready,
    output logic signed [VEC_WIDTH-1:0]        res [3],
    output logic                               saturated
);

    localparam int SUM_W = COEF_W + VEC_WIDTH + 2;
    localparam int TOP_W = SUM_W - ROUND_SHIFT - VEC_WIDTH + 1;
    localparam logic [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    logic                        s5_valid_reg;
    logic signed [VEC_WIDTH-1:0] s5_res_reg  [3];
    logic signed [VEC_WIDTH-1:0] s5_res_next [3];
    logic                        s5_sat_reg;
    logic                        s5_sat_next;
    logic                        adv5;

    assign adv5       = !s5_valid_reg || fwd_ready;
    assign item_ready = adv5;

    always_comb
    begin
        logic [TOP_W-1:0] top;
        s5_sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            top = sum[i][SUM_W-1:ROUND_SHIFT+VEC_WIDTH-1];
            if (top == '0 || top == '1)
                s5_res_next[i] = sum[i][ROUND_SHIFT+VEC_WIDTH-1:ROUND_SHIFT];
            else
            begin
                s5_res_next[i] = sum[i][SUM_W-1] ? VEC_MIN : VEC_MAX;
                s5_sat_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv5)
            s5_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            s5_res_reg <= s5_res_next;
            s5_sat_reg <= s5_sat_next;
        end
    end

    assign fwd_valid = s5_valid_reg;
    assign res       = s5_res_reg;
    assign saturated = s5_sat_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// Rotation testbench. Every accepted vector is run through a bit-exact
// integer predictor, and the expected result is queued in order; every
// result item is compared field by field with the head of that queue.
// A directed part covers field extremes, both rotation directions,
// round-half-up ties and clipping. Random phases follow, each with its
// own quaternion (extremes, full-range, near-unit), and one of them runs
// with no idling on either side. Registers are only written once the
// pipeline has drained.
module tb_top;
    import qvr_pkg::*;

    localparam int VW          = VEC_WIDTH_DEF;
    localparam int LATENCY     = 5;        // accept to result valid
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 230;
    localparam int STEADY_PH   = 3;        // phase run with no idling
    localparam int IDLE_PCT    = 11;

    // rotation direction carried in the mode field
    localparam logic MODE_FWD = 1'b0;      // q * v * conj(q)
    localparam logic MODE_INV = 1'b1;      // conj(q) * v * q

    localparam quat_word_t QMAX   = 16'sh7FFF;
    localparam quat_word_t QMIN   = 16'sh8000;
    localparam quat_word_t Q_HALF = 16'sd8192;     // 0.5
    localparam quat_word_t Q_R45  = 16'sd11585;    // cos(45 deg)

    typedef logic signed [VW-1:0] vec_word_t;

    localparam vec_word_t VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam vec_word_t VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam vec_word_t V1P0 = vec_word_t'(65536);   // 1.0

    typedef struct {
        vec_word_t x;
        vec_word_t y;
        vec_word_t z;
        logic      sat;
    } rot_result_t;

    // Holds the predictor's copy of q and the in-order queue of
    // rotated vectors still owed by the block.
    class rotation_scoreboard;
        quat_word_t  q_w, q_x, q_y, q_z;
        rot_result_t rotated_q[$];
        int          errors;

        function new();
            q_w    = ROT_W_RST;
            q_x    = ROT_V_RST;
            q_y    = ROT_V_RST;
            q_z    = ROT_V_RST;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, quat_word_t val);
            case (idx)
                CFG_ROT_W: q_w = val;
                CFG_ROT_X: q_x = val;
                CFG_ROT_Y: q_y = val;
                CFG_ROT_Z: q_z = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction

        // Exact rotation: 3x3 matrix in Q.28 applied to v, v split into
        // integer and fraction halves, round half up, clip.
        function void note_vector(logic mode, vec_word_t vx, vec_word_t vy, vec_word_t vz);
            longint      w, x, y, z, s, hsum, lsum, r, lo, hi;
            longint      v[3], vh[3], vl[3], m[3][3];
            vec_word_t   o[3];
            logic        sat;
            rot_result_t res;
            int          i, j;

            w = longint'(q_w);
            x = longint'(q_x);
            y = longint'(q_y);
            z = longint'(q_z);
            s = (mode == MODE_INV) ? -w : w;
            v[0] = longint'(vx);
            v[1] = longint'(vy);
            v[2] = longint'(vz);
            lo   = -(longint'(1) <<< (VW - 1));
            hi   = (longint'(1) <<< (VW - 1)) - 1;
            sat  = 1'b0;

            for (i = 0; i < 3; i++)
            begin
                vh[i] = v[i] >>> 16;
                vl[i] = v[i] - (vh[i] <<< 16);
            end

            m[0][0] = w * w + x * x - y * y - z * z;
            m[0][1] = 2 * (x * y - s * z);
            m[0][2] = 2 * (x * z + s * y);
            m[1][0] = 2 * (x * y + s * z);
            m[1][1] = w * w - x * x + y * y - z * z;
            m[1][2] = 2 * (y * z - s * x);
            m[2][0] = 2 * (x * z - s * y);
            m[2][1] = 2 * (y * z + s * x);
            m[2][2] = w * w - x * x - y * y + z * z;

            for (i = 0; i < 3; i++)
            begin
                hsum = 0;
                lsum = 0;
                for (j = 0; j < 3; j++)
                begin
                    hsum += m[i][j] * vh[j];
                    lsum += m[i][j] * vl[j];
                end
                // half an output lsb, then drop 28 fraction bits in two steps
                lsum += longint'(1) <<< (ROUND_SHIFT - 1);
                r = (hsum + (lsum >>> 16)) >>> (ROUND_SHIFT - 16);
                if (r > hi)
                begin
                    r   = hi;
                    sat = 1'b1;
                end
                if (r < lo)
                begin
                    r   = lo;
                    sat = 1'b1;
                end
                o[i] = vec_word_t'(r);
            end

            res.x   = o[0];
            res.y   = o[1];
            res.z   = o[2];
            res.sat = sat;
            rotated_q.push_back(res);
        endfunction

        function void check_result(rot_result_t got);
            rot_result_t want;
            if (rotated_q.size() == 0)
            begin
                $error("result item with no vector outstanding");
                errors++;
                return;
            end
            want = rotated_q.pop_front();
            if (got.x !== want.x)
            begin
                $error("out_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("out_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.z !== want.z)
            begin
                $error("out_z: expected %0d, got %0d", want.z, got.z);
                errors++;
            end
            if (got.sat !== want.sat)
            begin
                $error("saturated: expected %0b, got %0b", want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady;     // no idling on either side

    rotation_scoreboard sb = new();

    qvr_in_if  #(.VEC_WIDTH(VW)) sample_ch ();
    qvr_out_if #(.VEC_WIDTH(VW)) result_ch ();

    quaternion_vector_rotate #(
        .VEC_WIDTH (VW)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: random back-pressure, none in the steady phase
    always @(negedge clk)
    begin
        if (rst_n)
            result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        rot_result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.x   = result_ch.out_x;
            got.y   = result_ch.out_y;
            got.z   = result_ch.out_z;
            got.sat = result_ch.saturated;
            sb.check_result(got);
        end
    end

    // All tasks below start and end just after a falling edge.
    task automatic push_vector(logic mode, vec_word_t vx, vec_word_t vy, vec_word_t vz);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.mode  <= mode;
        sample_ch.in_x  <= vx;
        sample_ch.in_y  <= vy;
        sample_ch.in_z  <= vz;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_vector(mode, vx, vy, vz);
        @(negedge clk);
    endtask

    // write enable stays high across the four writes, dropped by the caller
    task automatic write_reg(cfg_idx_t idx, quat_word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic write_quat(quat_word_t w, quat_word_t x, quat_word_t y, quat_word_t z);
        write_reg(CFG_ROT_W, w);
        write_reg(CFG_ROT_X, x);
        write_reg(CFG_ROT_Y, y);
        write_reg(CFG_ROT_Z, z);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait for every owed result, then let the pipeline settle
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(negedge clk);
    endtask

    // random magnitude so that both clipped and in-range results occur
    function automatic vec_word_t rand_comp();
        vec_word_t r;
        r = vec_word_t'($urandom);
        if ($urandom_range(3) == 0)
            return r;
        return r >>> $urandom_range(1, 20);
    endfunction

    // near_unit keeps |q|^2 within about 2, else full 16-bit range
    function automatic quat_word_t rand_qword(bit near_unit);
        if (near_unit)
            return quat_word_t'(int'($urandom_range(0, 2 * Q_R45)) - Q_R45);
        return quat_word_t'($urandom);
    endfunction

    initial
    begin
        rst_n           = 1'b0;
        steady          = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_ROT_W;
        cfg_data        = '0;
        sample_ch.valid = 1'b0;
        sample_ch.mode  = MODE_FWD;
        sample_ch.in_x  = '0;
        sample_ch.in_y  = '0;
        sample_ch.in_z  = '0;
        result_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity after reset: extremes pass through unchanged
        push_vector(MODE_FWD, VMAX, VMIN, '0);
        push_vector(MODE_INV, VMIN, VMAX, -1);
        push_vector(MODE_FWD, 1, -1, V1P0);
        drain();

        // q = 0.5 scales by 0.25: half-lsb ties round toward +inf
        write_quat(Q_HALF, '0, '0, '0);
        push_vector(MODE_FWD, 2, -2, 6);
        push_vector(MODE_INV, -6, 1, -1);
        push_vector(MODE_FWD, 3, -3, 0);
        drain();

        // q = -2.0 scales by 4: clipping at both rails
        write_quat(QMIN, '0, '0, '0);
        push_vector(MODE_FWD, VMAX, VMIN, 1);
        push_vector(MODE_INV, vec_word_t'(24'sh200000), -vec_word_t'(24'sh200000), V1P0);
        drain();

        // 90 deg about z: forward and inverse turn opposite ways
        write_quat(Q_R45, '0, '0, Q_R45);
        push_vector(MODE_FWD, V1P0, '0, '0);
        push_vector(MODE_INV, V1P0, '0, '0);
        push_vector(MODE_FWD, '0, V1P0, -V1P0);
        push_vector(MODE_INV, VMAX, VMAX, VMIN);
        drain();

        // every component at its most negative value
        write_quat(QMIN, QMIN, QMIN, QMIN);
        push_vector(MODE_FWD, 1, 1, 1);
        push_vector(MODE_INV, -1, '0, 1);
        push_vector(MODE_FWD, VMIN, VMIN, VMIN);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: write_quat(QMAX, QMAX, QMAX, QMAX);
                1: write_quat(QMIN, QMIN, QMIN, QMIN);
                default: write_quat(rand_qword(p[0]), rand_qword(p[0]),
                                    rand_qword(p[0]), rand_qword(p[0]));
            endcase
            steady = (p == STEADY_PH);
            repeat (PHASE_ITEMS)
                push_vector(logic'($urandom_range(1)), rand_comp(), rand_comp(), rand_comp());
            drain();
            steady = 1'b0;
        end

        if (sb.pending() != 0)
        begin
            $error("%0d rotated vectors never came out", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
